// File: hw/rtl/modular_square_root_defines.svh
// ----------------------------------------------------------------------------
// modular square root assertion macros
// shared assertion helpers for the checker
// ----------------------------------------------------------------------------
`ifndef MODULAR_SQUARE_ROOT_DEFINES_SVH
`define MODULAR_SQUARE_ROOT_DEFINES_SVH

// clocked assertion, off during reset
`define MSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on the next clock
`define MSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg
// widths, status codes and shared unit request types
// ----------------------------------------------------------------------------
package msr_pkg;

  localparam int MOD_BITS         = 63;
  localparam int VAL_BITS         = 64;
  localparam int QNR_SEARCH_LIMIT = 1024;
  localparam int CNT_W            = $clog2(MOD_BITS + 1);
  localparam int QNR_W            = $clog2(QNR_SEARCH_LIMIT);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOROOT  = 2'd1,
    ST_EXHAUST = 2'd2
  } status_e;

  typedef struct packed {
    logic                start;
    logic [MOD_BITS-1:0] a;
    logic [VAL_BITS-1:0] b;
    logic [MOD_BITS-1:0] p;
  } mul_req_t;

  typedef struct packed {
    logic                done;
    logic [MOD_BITS-1:0] res;
  } mul_rsp_t;

endpackage

// File: hw/rtl/modular_square_root.sv
// ----------------------------------------------------------------------------
// modular_square_root
// tonelli-shanks square root modulo a configured prime
// ----------------------------------------------------------------------------
// One item at a time: s_axis_tready is high only while the sequencer is idle.
// Every modular product goes through one bit-serial multiplier. A modular power
// costs 63 squarings and up to 63 further products. Zero and modulus two
// finish after the reduction, a modulus below two without it; a non-residue
// takes one power; p = 3 mod 4 takes two; the general case takes one power
// per tried non-residue candidate, four more powers, and then O(s^2) single
// products in the Tonelli-Shanks loop, where p - 1 = q * 2^s.
// The result waits in an output register until taken.
module modular_square_root (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [msr_pkg::MOD_BITS-1:0] cfg_data_i,     // modulus
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [63:0]                  s_axis_tdata,   // value
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [127:0]                 m_axis_tdata,   // root_small, root_large, zero pad
  output logic [1:0]                   m_axis_tuser    // status
);

  localparam int MB = msr_pkg::MOD_BITS;
  localparam int CW = msr_pkg::CNT_W;
  localparam int QW = msr_pkg::QNR_W;
  localparam int NS = 22;

  typedef enum logic [NS-1:0] {
    S_IDLE = NS'(1) << 0,
    S_MW   = NS'(1) << 1,
    S_PSQ  = NS'(1) << 2,
    S_PSQD = NS'(1) << 3,
    S_PMD  = NS'(1) << 4,
    S_RED  = NS'(1) << 5,
    S_EUL  = NS'(1) << 6,
    S_SH3  = NS'(1) << 7,
    S_QS   = NS'(1) << 8,
    S_ZST  = NS'(1) << 9,
    S_ZCHK = NS'(1) << 10,
    S_C    = NS'(1) << 11,
    S_T    = NS'(1) << 12,
    S_R    = NS'(1) << 13,
    S_LCHK = NS'(1) << 14,
    S_LI   = NS'(1) << 15,
    S_LB   = NS'(1) << 16,
    S_LBD  = NS'(1) << 17,
    S_LC   = NS'(1) << 18,
    S_LT   = NS'(1) << 19,
    S_LR   = NS'(1) << 20,
    S_DONE = NS'(1) << 21
  } state_e;

  state_e state_q, state_d, mret_q, mret_d, pret_q, pret_d;

  logic [MB-1:0] p_q, p_d;
  logic          neg_q, neg_d;
  logic [MB-1:0] a_q, a_d, r_q, r_d, t_q, t_d, c_q, c_d, b_q, b_d;
  logic [MB-1:0] q_q, q_d, z_q, z_d, acc_q, acc_d, base_q, base_d, exp_q, exp_d;
  logic [MB-1:0] mres_q, mres_d;
  logic [CW-1:0] pcnt_q, pcnt_d, m_q, m_d, i_q, i_d, j_q, j_d;
  logic [QW-1:0] k_q, k_d;
  msr_pkg::status_e st_q, st_d;

  logic              ov_q, ov_d;
  logic [1:0]        ost_q, ost_d;
  logic [MB-1:0]     olo_q, olo_d, ohi_q, ohi_d;

  msr_pkg::mul_req_t mreq;
  msr_pkg::mul_rsp_t mrsp;

  logic [63:0]   vin, mag;
  logic [MB-1:0] av, other, pm1h, one, zinc;
  logic [MB:0]   pp1, qp1;
  logic [CW:0]   jsum;

  msr_mulmod u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'b00, ohi_q, olo_q};
  assign m_axis_tuser  = ost_q;

  always_comb begin
    one   = MB'(1);
    vin   = s_axis_tdata;
    mag   = vin[63] ? (64'd0 - vin) : vin;
    av    = (neg_q && (mres_q != '0)) ? (p_q - mres_q) : mres_q;
    pm1h  = (p_q - one) >> 1;
    pp1   = {1'b0, p_q} + (MB+1)'(1);
    qp1   = {1'b0, q_q} + (MB+1)'(1);
    other = p_q - r_q;
    zinc  = z_q + one;
    jsum  = {1'b0, j_q} + {1'b0, i_q} + (CW+1)'(1);
  end

  always_comb begin
    state_d = state_q;
    mret_d  = mret_q;
    pret_d  = pret_q;
    p_d     = p_q;
    neg_d   = neg_q;
    a_d     = a_q;
    r_d     = r_q;
    t_d     = t_q;
    c_d     = c_q;
    b_d     = b_q;
    q_d     = q_q;
    z_d     = z_q;
    acc_d   = acc_q;
    base_d  = base_q;
    exp_d   = exp_q;
    mres_d  = mres_q;
    pcnt_d  = pcnt_q;
    m_d     = m_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    st_d    = st_q;
    ov_d    = ov_q;
    ost_d   = ost_q;
    olo_d   = olo_q;
    ohi_d   = ohi_q;
    mreq.start = 1'b0;
    mreq.a     = '0;
    mreq.b     = '0;
    mreq.p     = p_q;

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end
    if (cfg_valid_i) begin
      p_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (p_q < MB'(2)) begin
            st_d    = msr_pkg::ST_OK;
            r_d     = '0;
            state_d = S_DONE;
          end else begin
            neg_d      = vin[63];
            mreq.start = 1'b1;
            mreq.a     = one;
            mreq.b     = mag;
            mret_d     = S_RED;
            state_d    = S_MW;
          end
        end
      end
      S_MW: begin
        if (mrsp.done) begin
          mres_d  = mrsp.res;
          state_d = mret_q;
        end
      end
      S_PSQ: begin
        if (pcnt_q == '0) begin
          state_d = pret_q;
        end else begin
          mreq.start = 1'b1;
          mreq.a     = acc_q;
          mreq.b     = {1'b0, acc_q};
          mret_d     = S_PSQD;
          state_d    = S_MW;
        end
      end
      S_PSQD: begin
        acc_d = mres_q;
        if (exp_q[MB-1]) begin
          mreq.start = 1'b1;
          mreq.a     = mres_q;
          mreq.b     = {1'b0, base_q};
          mret_d     = S_PMD;
          state_d    = S_MW;
        end else begin
          exp_d   = exp_q << 1;
          pcnt_d  = pcnt_q - 1'b1;
          state_d = S_PSQ;
        end
      end
      S_PMD: begin
        acc_d   = mres_q;
        exp_d   = exp_q << 1;
        pcnt_d  = pcnt_q - 1'b1;
        state_d = S_PSQ;
      end
      S_RED: begin
        a_d = av;
        if (av == '0) begin
          st_d    = msr_pkg::ST_OK;
          r_d     = '0;
          state_d = S_DONE;
        end else if (p_q == MB'(2)) begin
          st_d    = msr_pkg::ST_OK;
          r_d     = av;
          state_d = S_DONE;
        end else begin
          base_d  = av;
          exp_d   = pm1h;
          acc_d   = one;
          pcnt_d  = CW'(MB);
          pret_d  = S_EUL;
          state_d = S_PSQ;
        end
      end
      S_EUL: begin
        if (acc_q != one) begin
          st_d    = msr_pkg::ST_NOROOT;
          r_d     = '0;
          state_d = S_DONE;
        end else if (p_q[1:0] == 2'b11) begin
          base_d  = a_q;
          exp_d   = {1'b0, pp1[MB:2]};
          acc_d   = one;
          pcnt_d  = CW'(MB);
          pret_d  = S_SH3;
          state_d = S_PSQ;
        end else begin
          q_d     = p_q - one;
          m_d     = '0;
          state_d = S_QS;
        end
      end
      S_SH3: begin
        st_d    = msr_pkg::ST_OK;
        r_d     = acc_q;
        state_d = S_DONE;
      end
      S_QS: begin
        if ((q_q != '0) && !q_q[0]) begin
          q_d = q_q >> 1;
          m_d = m_q + 1'b1;
        end else begin
          z_d     = MB'(2);
          k_d     = '0;
          state_d = S_ZST;
        end
      end
      S_ZST: begin
        base_d  = z_q;
        exp_d   = pm1h;
        acc_d   = one;
        pcnt_d  = CW'(MB);
        pret_d  = S_ZCHK;
        state_d = S_PSQ;
      end
      S_ZCHK: begin
        if ((acc_q != '0) && (acc_q != one)) begin
          base_d  = z_q;
          exp_d   = q_q;
          acc_d   = one;
          pcnt_d  = CW'(MB);
          pret_d  = S_C;
          state_d = S_PSQ;
        end else if (k_q == QW'(msr_pkg::QNR_SEARCH_LIMIT - 1)) begin
          st_d    = msr_pkg::ST_EXHAUST;
          r_d     = '0;
          state_d = S_DONE;
        end else begin
          k_d     = k_q + 1'b1;
          z_d     = (zinc == p_q) ? '0 : zinc;
          state_d = S_ZST;
        end
      end
      S_C: begin
        c_d     = acc_q;
        base_d  = a_q;
        exp_d   = q_q;
        acc_d   = one;
        pcnt_d  = CW'(MB);
        pret_d  = S_T;
        state_d = S_PSQ;
      end
      S_T: begin
        t_d     = acc_q;
        base_d  = a_q;
        exp_d   = qp1[MB:1];
        acc_d   = one;
        pcnt_d  = CW'(MB);
        pret_d  = S_R;
        state_d = S_PSQ;
      end
      S_R: begin
        r_d     = acc_q;
        state_d = S_LCHK;
      end
      S_LCHK: begin
        if (t_q == one) begin
          st_d    = msr_pkg::ST_OK;
          state_d = S_DONE;
        end else begin
          i_d        = CW'(1);
          mreq.start = 1'b1;
          mreq.a     = t_q;
          mreq.b     = {1'b0, t_q};
          mret_d     = S_LI;
          state_d    = S_MW;
        end
      end
      S_LI: begin
        if ((mres_q != one) && (i_q < m_q)) begin
          i_d        = i_q + 1'b1;
          mreq.start = 1'b1;
          mreq.a     = mres_q;
          mreq.b     = {1'b0, mres_q};
          mret_d     = S_LI;
          state_d    = S_MW;
        end else if ((mres_q != one) || (i_q >= m_q)) begin
          st_d    = msr_pkg::ST_EXHAUST;
          r_d     = '0;
          state_d = S_DONE;
        end else begin
          b_d     = c_q;
          j_d     = '0;
          state_d = S_LB;
        end
      end
      S_LB: begin
        mreq.start = 1'b1;
        mreq.a     = b_q;
        mreq.b     = {1'b0, b_q};
        state_d    = S_MW;
        if (jsum < {1'b0, m_q}) begin
          mret_d = S_LBD;
        end else begin
          m_d    = i_q;
          mret_d = S_LC;
        end
      end
      S_LBD: begin
        b_d     = mres_q;
        j_d     = j_q + 1'b1;
        state_d = S_LB;
      end
      S_LC: begin
        c_d        = mres_q;
        mreq.start = 1'b1;
        mreq.a     = t_q;
        mreq.b     = {1'b0, mres_q};
        mret_d     = S_LT;
        state_d    = S_MW;
      end
      S_LT: begin
        t_d        = mres_q;
        mreq.start = 1'b1;
        mreq.a     = r_q;
        mreq.b     = {1'b0, b_q};
        mret_d     = S_LR;
        state_d    = S_MW;
      end
      S_LR: begin
        r_d     = mres_q;
        state_d = S_LCHK;
      end
      S_DONE: begin
        if (!ov_q || m_axis_tready) begin
          ov_d  = 1'b1;
          ost_d = st_q;
          if ((st_q == msr_pkg::ST_OK) && (r_q != '0)) begin
            olo_d = (r_q < other) ? r_q : other;
            ohi_d = (r_q < other) ? other : r_q;
          end else begin
            olo_d = '0;
            ohi_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mret_q  <= S_IDLE;
      pret_q  <= S_IDLE;
      p_q     <= MB'(3);
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mret_q  <= mret_d;
      pret_q  <= pret_d;
      p_q     <= p_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    a_q    <= a_d;
    r_q    <= r_d;
    t_q    <= t_d;
    c_q    <= c_d;
    b_q    <= b_d;
    q_q    <= q_d;
    z_q    <= z_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    exp_q  <= exp_d;
    mres_q <= mres_d;
    pcnt_q <= pcnt_d;
    m_q    <= m_d;
    i_q    <= i_d;
    j_q    <= j_d;
    k_q    <= k_d;
    st_q   <= st_d;
    ost_q  <= ost_d;
    olo_q  <= olo_d;
    ohi_q  <= ohi_d;
  end

endmodule

// File: hw/rtl/msr_mulmod.sv
// ----------------------------------------------------------------------------
// msr_mulmod
// bit-serial modular multiplier, msb first double and add, 64 steps
// ----------------------------------------------------------------------------
module msr_mulmod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  msr_pkg::mul_req_t req_i,
  output msr_pkg::mul_rsp_t rsp_o
);

  localparam int Steps = msr_pkg::VAL_BITS;
  localparam int SW    = $clog2(Steps);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [SW-1:0]                cnt_q, cnt_d;
  logic [msr_pkg::MOD_BITS-1:0] acc_q, acc_d;
  logic [msr_pkg::MOD_BITS-1:0] a_q, a_d;
  logic [msr_pkg::VAL_BITS-1:0] b_q, b_d;
  logic [msr_pkg::VAL_BITS-1:0] d1, d2, pw;

  always_comb begin
    pw = {1'b0, req_i.p};
    d1 = {acc_q, 1'b0};
    if (d1 >= pw) begin
      d1 = d1 - pw;
    end
    d2 = d1 + (b_q[msr_pkg::VAL_BITS-1] ? {1'b0, a_q} : '0);
    if (d2 >= pw) begin
      d2 = d2 - pw;
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    if (busy_q) begin
      acc_d = d2[msr_pkg::MOD_BITS-1:0];
      b_d   = {b_q[msr_pkg::VAL_BITS-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == SW'(Steps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = '0;
      a_d    = req_i.a;
      b_d    = req_i.b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = acc_q;

endmodule

// File: hw/rtl/msr_checker.sv
// ----------------------------------------------------------------------------
// msr_checker
// port-level checks on the modular square root, bound to the top level
// ----------------------------------------------------------------------------
`include "modular_square_root_defines.svh"

module msr_port_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [127:0]                 m_axis_tdata,
  input logic [1:0]                   m_axis_tuser
);

  `MSR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  `MSR_ASSERT(a_fail_zero, !(m_axis_tvalid && (m_axis_tuser != 2'd0)) || (m_axis_tdata == '0), "roots nonzero on failed status")
  `MSR_ASSERT(a_root_order, !m_axis_tvalid || (m_axis_tdata[62:0] <= m_axis_tdata[125:63]), "roots out of order")
  `MSR_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item taken while busy")

endmodule

bind modular_square_root msr_port_checker u_msr_checker (.*);

// File: tb/sv/msr_checker.sv
// ----------------------------------------------------------------------------
// msr_checker
// Watches the modulus, input and result channels of the modular square root.
// For every accepted input item it computes both expected roots and the
// status from its own copy of the modulus, queues them, and compares each
// accepted result field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module msr_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [msr_pkg::MOD_BITS-1:0] cfg_data_i,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [63:0]                  s_tdata_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [127:0]                 m_tdata_i,
  input  logic [1:0]                   m_tuser_i,
  output int                           pending_o,
  output int                           errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import msr_pkg::*;

  typedef logic [63:0] u64_t;

  typedef struct packed {
    status_e             status;
    logic [MOD_BITS-1:0] root_small;
    logic [MOD_BITS-1:0] root_large;
  } root_t;

  u64_t  mod_q;
  root_t root_q[$];
  int    errors;

  assign pending_o = root_q.size();
  assign errors_o  = errors;

  function automatic u64_t mul_mod(u64_t a, u64_t b, u64_t p);
    logic [127:0] prod;
    prod = {64'd0, a % p} * {64'd0, b % p};
    return u64_t'(prod % {64'd0, p});
  endfunction

  function automatic u64_t pow_mod(u64_t base, u64_t e, u64_t p);
    u64_t acc;
    acc  = 64'd1 % p;
    base = base % p;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, base, p);
      base = mul_mod(base, base, p);
      e    = e >> 1;
    end
    return acc;
  endfunction

  // status code, root through ref argument
  function automatic status_e tonelli(u64_t a, u64_t p, ref u64_t root);
    u64_t q, z, c, t, r, b, tmp, m, i, v;
    int   s;
    bit   found;
    s = 0;
    z = 0;
    found = 0;
    if (a == 0) begin root = 0; return ST_OK; end
    if (p == 2) begin root = a; return ST_OK; end
    if (pow_mod(a, (p - 1) / 2, p) != 1) return ST_NOROOT;
    if (p[1:0] == 2'b11) begin
      root = pow_mod(a, (p + 1) / 4, p);
      return ST_OK;
    end
    q = p - 1;
    while (q != 0 && !q[0]) begin q = q >> 1; s++; end
    for (int k = 0; k < QNR_SEARCH_LIMIT && !found; k++) begin
      v = pow_mod(64'd2 + k, (p - 1) / 2, p);
      if (v != 0 && v != 1) begin z = 64'd2 + k; found = 1; end
    end
    if (!found) return ST_EXHAUST;
    m = s;
    c = pow_mod(z, q, p);
    t = pow_mod(a, q, p);
    r = pow_mod(a, (q + 1) / 2, p);
    while (t != 1) begin
      i = 1;
      tmp = mul_mod(t, t, p);
      while (tmp != 1 && i < m) begin tmp = mul_mod(tmp, tmp, p); i++; end
      if (tmp != 1 || i >= m) return ST_EXHAUST;
      b = c;
      for (u64_t j = 0; j + i + 1 < m; j++) b = mul_mod(b, b, p);
      m = i;
      c = mul_mod(b, b, p);
      t = mul_mod(t, c, p);
      r = mul_mod(r, b, p);
    end
    root = r;
    return ST_OK;
  endfunction

  function automatic root_t predict_root(u64_t v, u64_t p);
    root_t   res;
    u64_t    a, r, rem, other;
    status_e st;
    res = '0;
    r   = 0;
    if (p < 2) return res;
    if (v[63]) begin
      rem = (64'd0 - v) % p;
      a   = (rem == 0) ? 64'd0 : p - rem;
    end else begin
      a = v % p;
    end
    st = tonelli(a, p, r);
    res.status = st;
    if (st == ST_OK && r != 0) begin
      other = p - r;
      res.root_small = (r < other) ? r[MOD_BITS-1:0] : other[MOD_BITS-1:0];
      res.root_large = (r < other) ? other[MOD_BITS-1:0] : r[MOD_BITS-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    root_t exp_r;
    if (!rst_ni) begin
      mod_q  <= 64'd3;
      errors <= 0;
      root_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) mod_q <= {1'b0, cfg_data_i};
      if (m_tvalid_i && m_tready_i) begin
        if (root_q.size() == 0) begin
          if (errors < 10) $display("unexpected result item %h %h", m_tuser_i, m_tdata_i);
          errors <= errors + 1;
        end else begin
          exp_r = root_q.pop_front();
          if (m_tuser_i != exp_r.status || m_tdata_i[62:0] != exp_r.root_small ||
              m_tdata_i[125:63] != exp_r.root_large || m_tdata_i[127:126] != 2'b00) begin
            if (errors < 10)
              $display("mismatch: exp st %0d lo %0d hi %0d, got st %0d lo %0d hi %0d",
                       exp_r.status, exp_r.root_small, exp_r.root_large,
                       m_tuser_i, m_tdata_i[62:0], m_tdata_i[125:63]);
            errors <= errors + 1;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) root_q.push_back(predict_root(s_tdata_i, mod_q));
    end
  end
endmodule

// File: tb/sv/tb_modular_square_root.sv
// ----------------------------------------------------------------------------
// tb_modular_square_root
// Drives the modular square root through moduli zero, one, two, small primes
// of both residues mod 4, a small composite, a large prime and the largest
// modulus. Every setting gets random values, many of them true squares; the
// first three directed ones too; random gaps and one long output stall.
// ----------------------------------------------------------------------------
module tb_modular_square_root;
  timeunit 1ns;
  timeprecision 1ps;
  import msr_pkg::*;

  localparam longint LIMIT = 60_000_000;

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                cfg_valid_i = 0;
  logic                cfg_ready_o;
  logic [MOD_BITS-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 0;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 0;
  logic [127:0]        m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  int                  pending, errors;
  bit                  hold_req = 0;
  longint              cycles = 0;
  logic [63:0]         cur_mod = 64'd3;

  modular_square_root dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  msr_checker chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .m_tuser_i(m_axis_tuser), .pending_o(pending), .errors_o(errors)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // receiver with random stalls and one long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 0;
        repeat (40000) @(negedge clk_i);
        hold_req = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready = 0;
        repeat (gap_len()) @(negedge clk_i);
      end
      m_axis_tready = 1;
    end
  end

  task automatic send_value(logic [63:0] v);
    repeat (gap_len()) @(negedge clk_i);
    s_axis_tvalid = 1;
    s_axis_tdata  = v;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 0;
  endtask

  task automatic set_modulus(logic [MOD_BITS-1:0] p);
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    cfg_valid_i = 1;
    cfg_data_i  = p;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 0;
    cur_mod = {1'b0, p};
  endtask

  function automatic logic [63:0] random_value();
    logic [127:0] sq;
    logic [63:0]  r;
    int           k;
    k = $urandom_range(0, 9);
    r = {$urandom, $urandom};
    if (k < 3 || cur_mod < 2) return r;
    if (k < 5) return 64'($signed($urandom_range(0, 200)) - 100);
    r  = r % cur_mod;
    sq = ({64'd0, r} * {64'd0, r}) % {64'd0, cur_mod};
    if (k < 8) return sq[63:0];
    return sq[63:0] - cur_mod;
  endfunction

  initial begin
    logic [62:0] mods[10];
    mods = '{63'd3, 63'd13, 63'd2, 63'd0, 63'd17, 63'd1, 63'd998244353,
             63'd21, 63'h7FFF_FFFF_FFFF_FFE7, 63'h7FFF_FFFF_FFFF_FFFF};
    repeat (11) @(negedge clk_i);
    rst_ni = 1;
    foreach (mods[i]) begin
      if (i != 0) set_modulus(mods[i]);
      if (i < 3) begin
        send_value(64'd0);
        send_value(64'd1);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h7FFF_FFFF_FFFF_FFFF);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        send_value(64'd4);
        send_value(64'd5);
      end
      if (i == 1) hold_req = 1;
      repeat (10) send_value(random_value());
    end
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
